FILE: src/fpalu_pkg.sv
package fpalu_pkg;

  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned WordWidthDef = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4,
    OP_DEC = 3'd5,
    OP_MIN = 3'd6,
    OP_MAX = 3'd7
  } opcode_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               overflow_flag;
    logic               divide_by_zero;
  } out_t;

endpackage

FILE: src/fixed_point_alu.sv
// Signed fixed-point ALU, WORD_WIDTH-bit two's complement words with FRAC_BITS
// fraction bits. Add, sub, increment and decrement are exact; multiply and
// divide round half away from zero. Out-of-range results saturate and set
// overflow_flag; divide by zero sets divide_by_zero and saturates by the sign
// of operand_a (zero for a zero dividend). Every result also carries the
// less / equal / greater compare of operand_a against operand_b.
// Input channel: in_valid_i / in_stall_o / in_data_i, one item per accept.
// Output channel: out_valid_o / out_stall_i / out_data_o, one result per item,
// in order.
// The pipeline holds an input register, an operand prep stage, one
// restoring-divide stage per quotient bit and the output register. The
// multiplier runs as four half-width partial products, a summing stage and a
// rounding stage alongside the first divide stages. One item is accepted
// every cycle while in_stall_o is low.
// When the output is stalled while holding a result, the whole pipeline
// freezes and in_stall_o rises; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS  = fpalu_pkg::FracBitsDef,
  parameter int unsigned WORD_WIDTH = fpalu_pkg::WordWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fpalu_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fpalu_pkg::out_t out_data_o
);

  localparam int unsigned W    = WORD_WIDTH;
  localparam int unsigned QW   = WORD_WIDTH + FRAC_BITS;
  localparam int unsigned HW   = (WORD_WIDTH + 1) / 2;
  localparam int unsigned PW   = 4 * HW + 1;
  localparam int unsigned MAGW = (PW > QW + 1) ? PW : QW + 1;

  localparam logic [PW-1:0] Rnd =
    PW'(FRAC_BITS > 0) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0);
  localparam logic [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    fpalu_pkg::opcode_e     op;
    logic                   neg;
    logic                   lt;
    logic                   eq;
    logic                   gt;
    logic                   ovf;
    logic                   dz;
    logic [W-1:0]           res;
    logic [W-1:0]           ma;
    logic [W-1:0]           mb;
    logic [W-1:0]           rem;
    logic [QW-1:0]          num;
    logic [QW-1:0]          quot;
    logic [3:0][2*HW-1:0]   pp;
    logic [PW-1:0]          prod;
  } stg_t;

  // {ovf, res} from sign and magnitude
  function automatic logic [W:0] sat_fn(logic neg, logic [MAGW-1:0] mag);
    logic [MAGW-1:0] half;
    logic            over;
    logic [W-1:0]    val;
    half = MAGW'(1) << (W - 1);
    over = neg ? (mag > half) : (mag >= half);
    val  = neg ? (W'(0) - mag[W-1:0]) : mag[W-1:0];
    if (over) begin
      val = neg ? WMin : WMax;
    end
    return {over, val};
  endfunction

  function automatic stg_t step_fn(stg_t s, int unsigned k);
    stg_t          n;
    logic [W:0]    rem_sh;
    logic          ge;
    logic [2*HW-1:0] am;
    logic [2*HW-1:0] bm;
    logic [PW-1:0] rnd;
    n = s;
    // one quotient bit per stage
    rem_sh = {s.rem, s.num[QW-1]};
    ge     = rem_sh >= {1'b0, s.mb};
    n.rem  = ge ? W'(rem_sh - {1'b0, s.mb}) : rem_sh[W-1:0];
    n.num  = s.num << 1;
    n.quot = {s.quot[QW-2:0], ge};
    am = (2*HW)'(s.ma);
    bm = (2*HW)'(s.mb);
    if (k == 0) begin
      n.pp[0] = (2*HW)'(am[HW-1:0] * bm[HW-1:0]);
      n.pp[1] = (2*HW)'(am[HW-1:0] * bm[2*HW-1:HW]);
      n.pp[2] = (2*HW)'(am[2*HW-1:HW] * bm[HW-1:0]);
      n.pp[3] = (2*HW)'(am[2*HW-1:HW] * bm[2*HW-1:HW]);
    end else if (k == 1) begin
      n.prod = PW'(s.pp[0]) + (PW'(s.pp[1]) << HW) + (PW'(s.pp[2]) << HW)
             + (PW'(s.pp[3]) << (2 * HW));
    end else if (k == 2) begin
      if (s.op == fpalu_pkg::OP_MUL) begin
        rnd = (s.prod + Rnd) >> FRAC_BITS;
        {n.ovf, n.res} = sat_fn(s.neg, MAGW'(rnd));
      end
    end
    return n;
  endfunction

  logic en;

  logic               in_vld_q;
  fpalu_pkg::opcode_e op_q;
  logic [W-1:0]       a_q;
  logic [W-1:0]       b_q;

  logic [QW:0] vld_q;
  stg_t        st_q [QW+1];
  stg_t        prep_d;

  logic            out_vld_q;
  fpalu_pkg::out_t out_q;
  fpalu_pkg::out_t out_d;

  assign en          = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= fpalu_pkg::opcode_e'(in_data_i.opcode);
      a_q  <= W'(in_data_i.operand_a);
      b_q  <= W'(in_data_i.operand_b);
    end
  end

  // operand prep: compares, magnitudes and the exact short ops
  always_comb begin
    logic [W:0] sa;
    logic [W:0] sum;
    logic       sovf;
    logic [W-1:0] sres;
    sa  = {a_q[W-1], a_q};
    sum = sa + {b_q[W-1], b_q};
    unique case (op_q)
      fpalu_pkg::OP_SUB: sum = sa - {b_q[W-1], b_q};
      fpalu_pkg::OP_INC: sum = sa + (W+1)'(1);
      fpalu_pkg::OP_DEC: sum = sa - (W+1)'(1);
      default:           sum = sa + {b_q[W-1], b_q};
    endcase
    sovf = sum[W] ^ sum[W-1];
    sres = sovf ? (sum[W] ? WMin : WMax) : sum[W-1:0];

    prep_d      = '0;
    prep_d.op   = op_q;
    prep_d.lt   = $signed(a_q) < $signed(b_q);
    prep_d.eq   = a_q == b_q;
    prep_d.gt   = $signed(a_q) > $signed(b_q);
    prep_d.neg  = a_q[W-1] ^ b_q[W-1];
    prep_d.ma   = a_q[W-1] ? (W'(0) - a_q) : a_q;
    prep_d.mb   = b_q[W-1] ? (W'(0) - b_q) : b_q;
    prep_d.num  = QW'(prep_d.ma) << FRAC_BITS;

    unique case (op_q) inside
      fpalu_pkg::OP_ADD, fpalu_pkg::OP_SUB, fpalu_pkg::OP_INC, fpalu_pkg::OP_DEC: begin
        prep_d.res = sres;
        prep_d.ovf = sovf;
      end
      fpalu_pkg::OP_MIN: prep_d.res = prep_d.lt ? a_q : b_q;
      fpalu_pkg::OP_MAX: prep_d.res = prep_d.gt ? a_q : b_q;
      fpalu_pkg::OP_DIV: begin
        if (b_q == '0) begin
          prep_d.dz  = 1'b1;
          prep_d.res = (a_q == '0) ? '0 : (a_q[W-1] ? WMin : WMax);
        end
      end
      fpalu_pkg::OP_MUL: prep_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= prep_d;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k+1] <= step_fn(st_q[k], k);
      end
    end
  end

  // divide rounding and final packing
  always_comb begin
    stg_t       s;
    logic       up;
    logic [W:0] pk;
    s  = st_q[QW];
    up = {s.rem, 1'b0} >= {1'b0, s.mb};
    pk = sat_fn(s.neg, MAGW'(s.quot) + MAGW'(up));
    out_d.result_value   = 32'(s.res);
    out_d.overflow_flag  = s.ovf;
    if (s.op == fpalu_pkg::OP_DIV && !s.dz) begin
      out_d.result_value  = 32'(pk[W-1:0]);
      out_d.overflow_flag = pk[W];
    end
    out_d.is_less        = s.lt;
    out_d.is_equal       = s.eq;
    out_d.is_greater     = s.gt;
    out_d.divide_by_zero = s.dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  a_one_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_data_o.is_less, out_data_o.is_equal,
                             out_data_o.is_greater}))
    else $error("compare flags not exclusive");

  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |-> !out_data_o.overflow_flag)
    else $error("divide by zero with overflow");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output held");

endmodule
